// ----- sv/bcel_pkg.sv -----
package bcel_pkg;

    typedef logic [16:0] t_q16;   // probability / weight, Q1.16, 0..65536
    typedef logic [19:0] t_nl;    // -ln term, Q4.16

    typedef struct packed {
        t_q16 p;                  // teacher win probability
        t_q16 t;                  // outcome target
        t_q16 m;                  // blended target
    } t_wts;

    localparam t_q16        ONE_Q16   = 17'd65536;
    localparam t_q16        HALF_Q16  = 17'd32768;
    // ceil(2^37 / 75): floor(mag * 2^14 / 75) == (mag * RECIP_300) >> 23
    localparam logic [30:0] RECIP_300 = 31'd1832519380;
    localparam logic [6:0]  SIG_LAST  = 7'd24;
    localparam logic [32:0] EPS_Q32   = 33'd4295;
    localparam logic [20:0] LN2_Q16   = 21'd45426;
    localparam logic [20:0] LOG_BIAS  = 21'd1453632;   // 32 * ln2
    localparam logic [21:0] OUT_MAX   = 22'd1048575;

    localparam logic [1:0] OC_LOSS = 2'd0;
    localparam logic [1:0] OC_DRAW = 2'd1;
    localparam logic [1:0] OC_WIN  = 2'd2;

    localparam logic [1:0] REG_BLEND_WEIGHT      = 2'd0;
    localparam logic [1:0] REG_BLEND_WEIGHT_HIGH = 2'd1;
    localparam logic [1:0] REG_BLEND_LIMIT       = 2'd2;
    localparam logic [1:0] REG_WIN_TARGET        = 2'd3;

    // round(65536 * sigmoid(k/2))
    function automatic t_q16 sig_tab(input logic [4:0] k);
        t_q16 v;
        case (k)
            5'd0:  v = 17'd32768;
            5'd1:  v = 17'd40793;
            5'd2:  v = 17'd47911;
            5'd3:  v = 17'd53581;
            5'd4:  v = 17'd57724;
            5'd5:  v = 17'd60565;
            5'd6:  v = 17'd62428;
            5'd7:  v = 17'd63615;
            5'd8:  v = 17'd64357;
            5'd9:  v = 17'd64816;
            5'd10: v = 17'd65097;
            5'd11: v = 17'd65269;
            5'd12: v = 17'd65374;
            5'd13: v = 17'd65438;
            5'd14: v = 17'd65476;
            5'd15: v = 17'd65500;
            5'd16: v = 17'd65514;
            5'd17: v = 17'd65523;
            5'd18: v = 17'd65528;
            5'd19: v = 17'd65531;
            5'd20: v = 17'd65533;
            5'd21: v = 17'd65534;
            5'd22: v = 17'd65535;
            5'd23: v = 17'd65535;
            default: v = 17'd65536;
        endcase
        return v;
    endfunction

    // round(65536 * ln(1 + k/16))
    function automatic logic [15:0] ln_tab(input logic [4:0] k);
        logic [15:0] v;
        case (k)
            5'd0:  v = 16'd0;
            5'd1:  v = 16'd3973;
            5'd2:  v = 16'd7719;
            5'd3:  v = 16'd11262;
            5'd4:  v = 16'd14624;
            5'd5:  v = 16'd17821;
            5'd6:  v = 16'd20870;
            5'd7:  v = 16'd23783;
            5'd8:  v = 16'd26573;
            5'd9:  v = 16'd29248;
            5'd10: v = 16'd31818;
            5'd11: v = 16'd34292;
            5'd12: v = 16'd36675;
            5'd13: v = 16'd38975;
            5'd14: v = 16'd41196;
            5'd15: v = 16'd43345;
            default: v = 16'd45426;
        endcase
        return v;
    endfunction

    function automatic t_q16 clamp_one(input t_q16 v);
        return (v > ONE_Q16) ? ONE_Q16 : v;
    endfunction

endpackage

// ----- sv/blended_cross_entropy_loss.sv -----
// channel  | dir | handshake                          | payload
// s_axis   | in  | i_s_axis_tvalid / o_s_axis_tready  | i_s_axis_tdata[39:0]
// m_axis   | out | o_m_axis_tvalid / i_m_axis_tready  | o_m_axis_tdata[119:0]
// cfg      | in  | i_cfg_we (no wait)                 | i_cfg_addr, i_cfg_data
//
// 11-stage pipeline, one request per cycle unless the output stalls a full pipe;
// o_m_axis_tvalid is the valid bit of the last stage. Depth is set by
// sigmoid (3), blend (2), log unit (4) and the entropy multiply/sum (2).
// Each stage has its own valid and enable, so a stalled output only freezes
// stages that are full; bubbles are squeezed out. Reset (sync, active low)
// empties the pipe and loads register defaults.
module blended_cross_entropy_loss
    import bcel_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // teacher_score[15:0], student_score[31:16], outcome[33:32], zero pad
    input  logic [39:0]  i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // xent_teacher, xent_outcome, xent_blend, ent_teacher, ent_outcome,
    // ent_blend, 20 bits each from bit 0
    output logic [119:0] o_m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [16:0]  i_cfg_data
);

    localparam int NST = 11;

    logic [16:0] r_blend_weight, r_blend_weight_high, r_win_target;
    logic [14:0] r_blend_limit;

    logic [NST:1] r_vld;
    logic [NST:1] en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_weight      <= 17'd21627;
            r_blend_weight_high <= 17'd21627;
            r_blend_limit       <= 15'd32000;
            r_win_target        <= 17'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_BLEND_WEIGHT:      r_blend_weight      <= i_cfg_data;
                REG_BLEND_WEIGHT_HIGH: r_blend_weight_high <= i_cfg_data;
                REG_BLEND_LIMIT:       r_blend_limit       <= i_cfg_data[14:0];
                REG_WIN_TARGET:        r_win_target        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage k loads when empty or when stage k+1 moves on
    always_comb begin
        en[NST] = !r_vld[NST] || i_m_axis_tready;
        for (int k = NST - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_axis_tready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) r_vld[1] <= i_s_axis_tvalid;
            for (int k = 2; k <= NST; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // ---- stage 1: |s| * 2^14 / 75, target and weight select
    logic [15:0] s_score [2];
    logic [15:0] s_mag   [2];
    logic [46:0] s_prod  [2];
    logic [1:0]  s_oc;
    t_q16        s_w, s_t, s_lam;

    logic [22:0] r_u1   [2];
    logic        r_neg1 [2];
    t_q16        r_t1, r_lam1;

    always_comb begin
        s_score[0] = i_s_axis_tdata[15:0];
        s_score[1] = i_s_axis_tdata[31:16];
        for (int l = 0; l < 2; l++) begin
            s_mag[l]  = s_score[l][15] ? 16'(-s_score[l]) : s_score[l];
            s_prod[l] = {31'd0, s_mag[l]} * {16'd0, RECIP_300};
        end
        s_oc = i_s_axis_tdata[33:32];
        s_w  = clamp_one(r_win_target);
        case (s_oc)
            OC_WIN:  s_t = s_w;
            OC_LOSS: s_t = ONE_Q16 - s_w;
            default: s_t = HALF_Q16;  // draw and the unused code
        endcase
        s_lam = clamp_one((s_mag[0] >= {1'b0, r_blend_limit}) ?
                          r_blend_weight_high : r_blend_weight);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            for (int l = 0; l < 2; l++) begin
                r_u1[l]   <= s_prod[l][45:23];
                r_neg1[l] <= s_score[l][15];
            end
            r_t1   <= s_t;
            r_lam1 <= s_lam;
        end
    end

    // ---- stage 2: table lookup, slope times fraction
    logic [4:0]  s_k    [2];
    t_q16        s_lo   [2];
    t_q16        s_hi   [2];
    logic [12:0] s_diff [2];
    logic [28:0] s_fp   [2];

    t_q16        r_lo2   [2];
    logic [12:0] r_fp2   [2];
    logic        r_sat2  [2];
    logic        r_neg2  [2];
    t_q16        r_t2, r_lam2;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            s_k[l]    = r_u1[l][20:16];
            s_lo[l]   = sig_tab(s_k[l]);
            s_hi[l]   = sig_tab(s_k[l] + 5'd1);
            s_diff[l] = 13'(s_hi[l] - s_lo[l]);
            s_fp[l]   = {16'd0, s_diff[l]} * {13'd0, r_u1[l][15:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            for (int l = 0; l < 2; l++) begin
                r_lo2[l]  <= s_lo[l];
                r_fp2[l]  <= s_fp[l][28:16];
                r_sat2[l] <= (r_u1[l][22:16] >= SIG_LAST);
                r_neg2[l] <= r_neg1[l];
            end
            r_t2   <= r_t1;
            r_lam2 <= r_lam1;
        end
    end

    // ---- stage 3: finish sigmoid, mirror negative scores
    t_q16 s_v  [2];
    t_q16 s_pq [2];
    t_q16 r_p3, r_q3, r_t3, r_lam3;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            s_v[l]  = r_sat2[l] ? ONE_Q16 : r_lo2[l] + {4'd0, r_fp2[l]};
            s_pq[l] = r_neg2[l] ? ONE_Q16 - s_v[l] : s_v[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_p3   <= s_pq[0];
            r_q3   <= s_pq[1];
            r_t3   <= r_t2;
            r_lam3 <= r_lam2;
        end
    end

    // ---- stage 4: blend products
    logic [33:0] r_mt4, r_mp4;
    t_q16        r_p4, r_q4, r_t4;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_mt4 <= 34'(ONE_Q16 - r_lam3) * 34'(r_t3);
            r_mp4 <= 34'(r_lam3) * 34'(r_p3);
            r_p4  <= r_p3;
            r_q4  <= r_q3;
            r_t4  <= r_t3;
        end
    end

    // ---- stage 5: blended target
    logic [34:0] s_msum;
    t_wts        r_w5;
    t_q16        r_q5;

    assign s_msum = {1'b0, r_mt4} + {1'b0, r_mp4};

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_w5.p <= r_p4;
            r_w5.t <= r_t4;
            r_w5.m <= s_msum[32:16];
            r_q5   <= r_q4;
        end
    end

    // ---- log unit, 8 lanes: q, 1-q, p, 1-p, t, 1-t, m, 1-m
    // stage 6: add epsilon, find top set bit
    t_q16        s_x [8];
    logic [32:0] s_a [8];
    logic [5:0]  s_n [8];
    logic [32:0] r_a6 [8];
    logic [5:0]  r_n6 [8];
    t_wts        r_w6;

    always_comb begin
        s_x[0] = r_q5;    s_x[1] = ONE_Q16 - r_q5;
        s_x[2] = r_w5.p;  s_x[3] = ONE_Q16 - r_w5.p;
        s_x[4] = r_w5.t;  s_x[5] = ONE_Q16 - r_w5.t;
        s_x[6] = r_w5.m;  s_x[7] = ONE_Q16 - r_w5.m;
        for (int l = 0; l < 8; l++) begin
            s_a[l] = {s_x[l], 16'd0} + EPS_Q32;
            s_n[l] = '0;
            for (int b = 0; b < 33; b++) begin
                if (s_a[l][b]) s_n[l] = 6'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_a6 <= s_a;
            r_n6 <= s_n;
            r_w6 <= r_w5;
        end
    end

    // stage 7: normalize to [1,2)
    logic [32:0] s_norm [8];
    logic [15:0] r_g7   [8];
    logic [5:0]  r_n7   [8];
    t_wts        r_w7;

    always_comb begin
        for (int l = 0; l < 8; l++) begin
            s_norm[l] = r_a6[l] << (6'd32 - r_n6[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            for (int l = 0; l < 8; l++) begin
                r_g7[l] <= s_norm[l][31:16];
            end
            r_n7 <= r_n6;
            r_w7 <= r_w6;
        end
    end

    // stage 8: exponent term, table and interpolation product
    logic [15:0] s_llo  [8];
    logic [15:0] s_lhi  [8];
    logic [11:0] s_ldif [8];
    logic [23:0] s_lp   [8];
    logic [20:0] r_base8 [8];
    logic [11:0] r_lf8   [8];
    t_wts        r_w8;

    always_comb begin
        for (int l = 0; l < 8; l++) begin
            s_llo[l]  = ln_tab({1'b0, r_g7[l][15:12]});
            s_lhi[l]  = ln_tab({1'b0, r_g7[l][15:12]} + 5'd1);
            s_ldif[l] = 12'(s_lhi[l] - s_llo[l]);
            s_lp[l]   = {12'd0, s_ldif[l]} * {12'd0, r_g7[l][11:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            for (int l = 0; l < 8; l++) begin
                r_base8[l] <= 21'(21'(r_n7[l]) * LN2_Q16) + {5'd0, s_llo[l]};
                r_lf8[l]   <= s_lp[l][23:12];
            end
            r_w8 <= r_w7;
        end
    end

    // stage 9: -ln(x + eps), clamped at zero
    logic [20:0] s_lna [8];
    t_nl         r_nl9 [8];
    t_wts        r_w9;

    always_comb begin
        for (int l = 0; l < 8; l++) begin
            s_lna[l] = r_base8[l] + {9'd0, r_lf8[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            for (int l = 0; l < 8; l++) begin
                r_nl9[l] <= (s_lna[l] > LOG_BIAS) ? '0 : 20'(LOG_BIAS - s_lna[l]);
            end
            r_w9 <= r_w8;
        end
    end

    // ---- stage 10: weighted terms; result r uses lanes 0, 1 for r < 3, else 2*(r-2), 2*(r-2)+1
    t_q16        s_hw  [6];
    t_nl         s_nla [6];
    t_nl         s_nlb [6];
    logic [36:0] r_ha10 [6];
    logic [36:0] r_hb10 [6];

    always_comb begin
        s_hw[0] = r_w9.p; s_nla[0] = r_nl9[0]; s_nlb[0] = r_nl9[1];
        s_hw[1] = r_w9.t; s_nla[1] = r_nl9[0]; s_nlb[1] = r_nl9[1];
        s_hw[2] = r_w9.m; s_nla[2] = r_nl9[0]; s_nlb[2] = r_nl9[1];
        s_hw[3] = r_w9.p; s_nla[3] = r_nl9[2]; s_nlb[3] = r_nl9[3];
        s_hw[4] = r_w9.t; s_nla[4] = r_nl9[4]; s_nlb[4] = r_nl9[5];
        s_hw[5] = r_w9.m; s_nla[5] = r_nl9[6]; s_nlb[5] = r_nl9[7];
    end

    always_ff @(posedge i_clk) begin
        if (en[10]) begin
            for (int r = 0; r < 6; r++) begin
                r_ha10[r] <= {20'd0, s_hw[r]} * {17'd0, s_nla[r]};
                r_hb10[r] <= {20'd0, ONE_Q16 - s_hw[r]} * {17'd0, s_nlb[r]};
            end
        end
    end

    // ---- stage 11: sum, scale, saturate into the output register
    logic [37:0] s_hsum [6];
    logic [21:0] s_hq   [6];
    logic [119:0] r_out11;

    always_comb begin
        for (int r = 0; r < 6; r++) begin
            s_hsum[r] = {1'b0, r_ha10[r]} + {1'b0, r_hb10[r]};
            s_hq[r]   = s_hsum[r][37:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[11]) begin
            for (int r = 0; r < 6; r++) begin
                r_out11[20*r +: 20] <= (s_hq[r] > OUT_MAX) ? OUT_MAX[19:0] : s_hq[r][19:0];
            end
        end
    end

    assign o_m_axis_tvalid = r_vld[NST];
    assign o_m_axis_tdata  = r_out11;

    // a full, stalled pipe must not take a request
    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted while pipeline full and stalled");

    // a stage that is held keeps its valid bit
    a_hold_keeps_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[5] && !en[5]) |=> r_vld[5])
        else $error("held stage lost its request");

    // probabilities stay within one
    a_prob_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (r_p3 <= ONE_Q16 && r_q3 <= ONE_Q16))
        else $error("sigmoid out of range");

    // blended target lies between outcome target and teacher probability
    a_blend_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> ((r_w5.m <= r_w5.p || r_w5.m <= r_w5.t) &&
                      (r_w5.m >= r_w5.p || r_w5.m >= r_w5.t)))
        else $error("blended target outside its bounds");

endmodule
